### rtl/core/dtbl_pkg.sv
// Shared types, codes and constants of the dual token bucket limiter.
// No dependencies; every other file of the block imports this package.
package dtbl_pkg;

   localparam int DEF_BURST_TICKS = 2000;
   localparam int DEF_LEVEL_BITS  = 48;

   localparam int RATE_BITS      = 20;
   localparam int COUNT_BITS     = 24;
   localparam int WAKE_BITS      = 24;
   localparam int ALLOW_BITS     = 31;
   localparam int CSR_INDEX_BITS = 1;

   localparam int SEGMENT    = 1460;
   localparam int MIN_WAKE   = 10;
   localparam int RATE_RESET = 1000000;

   localparam logic [1:0] CMD_TICK = 2'd0;
   localparam logic [1:0] CMD_EAT  = 2'd1;
   localparam logic [1:0] CMD_GET  = 2'd2;

   localparam logic DIR_READ  = 1'b0;
   localparam logic DIR_WRITE = 1'b1;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_READ_RATE  = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WRITE_RATE = 1'b1;

   typedef struct packed {
      logic [1:0]            cmd;
      logic                  direction;
      logic [COUNT_BITS-1:0] byte_count;
   } req_payload_type;

   typedef struct packed {
      logic [ALLOW_BITS-1:0] allowed_bytes;
      logic                  read_paused;
      logic                  write_paused;
      logic                  read_changed;
      logic                  write_changed;
      logic [WAKE_BITS-1:0]  read_wake_ticks;
      logic [WAKE_BITS-1:0]  write_wake_ticks;
   } rsp_payload_type;

   typedef struct packed {
      logic                 done;
      logic [WAKE_BITS-1:0] quot;
   } div_rsp_type;

   // Bucket cap at the reset rate.
   function automatic logic [63:0] reset_cap(input int unsigned burst);
      return 64'(burst) * 64'(RATE_RESET);
   endfunction

endpackage

### rtl/core/dual_token_bucket_limiter_top.sv
// Top level of the dual token bucket limiter: rate registers, caps, output register.
// Depends on dtbl_pkg and dtbl_ctrl (which holds dtbl_div).
//
//   port group  direction  handshake            carries
//   req_*       in         req_valid/req_stall  req_payload_type (cmd, direction, byte_count)
//   rsp_*       out        rsp_valid/rsp_stall  rsp_payload_type (allowance, pause, wake)
//   csr_*       in         csr_we               csr_index, csr_wdata (rate per tick)
//
// One transaction is taken at a time: both buckets are updated, then each direction
// is checked in turn, and each paused direction also waits on the shared serial
// divider (check, quotient steps and hand-back) for its wake delay.
// A rate write takes effect at once; the bucket is cut down in the next cycle,
// and no transaction is accepted in that cycle. Reset restores both rates and
// fills both buckets. A stalled result stays in the output register and holds
// back the next result, which waits in the sequencer until the register is free.
module dual_token_bucket_limiter_top #(
   parameter int BURST_TICKS = dtbl_pkg::DEF_BURST_TICKS,
   parameter int LEVEL_BITS  = dtbl_pkg::DEF_LEVEL_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  dtbl_pkg::req_payload_type           req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output dtbl_pkg::rsp_payload_type           rsp_payload,
   input  logic                                csr_we,
   input  logic [dtbl_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [dtbl_pkg::RATE_BITS-1:0]      csr_wdata
);
   import dtbl_pkg::*;

   localparam int BURST_BITS = $clog2(BURST_TICKS + 1);
   localparam int PROD_BITS  = BURST_BITS + RATE_BITS;
   localparam logic [LEVEL_BITS-1:0] CapReset = LEVEL_BITS'(reset_cap(BURST_TICKS));

   logic [RATE_BITS-1:0]  rate_ff [2];
   logic [RATE_BITS-1:0]  rate_in [2];
   logic [LEVEL_BITS-1:0] cap_ff [2];
   logic [LEVEL_BITS-1:0] cap_in [2];
   logic [1:0]            clip_ff, clip_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_payload_type       rsp_payload_ff, rsp_payload_in;
   logic [BURST_BITS-1:0] burst_c;
   logic [PROD_BITS-1:0]  cap_prod;
   logic                  out_free;
   logic                  load;
   rsp_payload_type       result;

   assign burst_c  = BURST_BITS'(BURST_TICKS);
   assign cap_prod = burst_c * csr_wdata;

   always_comb begin
      for (int i = 0; i < 2; i++) begin
         rate_in[i] = rate_ff[i];
         cap_in[i]  = cap_ff[i];
         clip_in[i] = 1'b0;
      end
      if (csr_we) begin
         case (csr_index)
            CSR_READ_RATE: begin
               rate_in[DIR_READ] = csr_wdata;
               cap_in[DIR_READ]  = LEVEL_BITS'(cap_prod);
               clip_in[DIR_READ] = 1'b1;
            end
            CSR_WRITE_RATE: begin
               rate_in[DIR_WRITE] = csr_wdata;
               cap_in[DIR_WRITE]  = LEVEL_BITS'(cap_prod);
               clip_in[DIR_WRITE] = 1'b1;
            end
            default: begin
               clip_in = '0;
            end
         endcase
      end
   end

   dtbl_ctrl #(
      .BURST_TICKS (BURST_TICKS),
      .LEVEL_BITS  (LEVEL_BITS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .csr_busy    (csr_we),
      .rate        (rate_ff),
      .cap         (cap_ff),
      .clip        (clip_ff),
      .out_free    (out_free),
      .load        (load),
      .result      (result)
   );

   // output register: free when empty or being taken this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (load) begin
         rsp_valid_in   = 1'b1;
         rsp_payload_in = result;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff[0]   <= RATE_BITS'(RATE_RESET);
         rate_ff[1]   <= RATE_BITS'(RATE_RESET);
         cap_ff[0]    <= CapReset;
         cap_ff[1]    <= CapReset;
         clip_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rate_ff[0]   <= rate_in[0];
         rate_ff[1]   <= rate_in[1];
         cap_ff[0]    <= cap_in[0];
         cap_ff[1]    <= cap_in[1];
         clip_ff      <= clip_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

### rtl/core/dtbl_div.sv
// Serial divider for the wake delay: saturating 24-bit quotient, one bit a cycle.
// Depends on dtbl_pkg.
module dtbl_div #(
   parameter int NUM_BITS = dtbl_pkg::DEF_LEVEL_BITS + 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [NUM_BITS-1:0]           num,
   input  logic [dtbl_pkg::RATE_BITS-1:0] den,
   output dtbl_pkg::div_rsp_type         rsp
);
   import dtbl_pkg::*;

   localparam int EXT_BITS = (NUM_BITS > WAKE_BITS + RATE_BITS) ?
                             NUM_BITS : WAKE_BITS + RATE_BITS + 1;
   localparam int HI_BITS  = EXT_BITS - WAKE_BITS;
   localparam int CNT_BITS = $clog2(WAKE_BITS);

   typedef enum logic [2:0] {
      D_IDLE  = 3'b001,
      D_CHECK = 3'b010,
      D_RUN   = 3'b100
   } div_state_type;

   div_state_type         state_ff, state_in;
   logic [EXT_BITS-1:0]   num_ff, num_in;
   logic [RATE_BITS-1:0]  den_ff, den_in;
   logic [RATE_BITS-1:0]  rem_ff, rem_in;
   logic [WAKE_BITS-1:0]  quo_ff, quo_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic                  done_ff, done_in;
   logic [RATE_BITS+1:0]  trial;
   logic                  trial_ok;

   assign trial    = {1'b0, rem_ff, quo_ff[WAKE_BITS-1]} - {2'b00, den_ff};
   assign trial_ok = !trial[RATE_BITS+1];

   always_comb begin
      state_in = state_ff;
      num_in   = num_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      case (state_ff)
         D_IDLE: begin
            if (start) begin
               num_in   = EXT_BITS'(num);
               den_in   = den;
               state_in = D_CHECK;
            end
         end
         D_CHECK: begin
            // quotient would not fit in 24 bits (also covers a zero divisor)
            if (num_ff[EXT_BITS-1:WAKE_BITS] >= HI_BITS'(den_ff)) begin
               quo_in   = '1;
               done_in  = 1'b1;
               state_in = D_IDLE;
            end else begin
               rem_in   = num_ff[WAKE_BITS+RATE_BITS-1:WAKE_BITS];
               quo_in   = num_ff[WAKE_BITS-1:0];
               cnt_in   = '0;
               state_in = D_RUN;
            end
         end
         D_RUN: begin
            rem_in = trial_ok ? trial[RATE_BITS-1:0] :
                                {rem_ff[RATE_BITS-2:0], quo_ff[WAKE_BITS-1]};
            quo_in = {quo_ff[WAKE_BITS-2:0], trial_ok};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_BITS'(WAKE_BITS - 1)) begin
               done_in  = 1'b1;
               state_in = D_IDLE;
            end
         end
         default: begin
            state_in = D_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quot = quo_ff;

endmodule

### rtl/core/dtbl_ctrl.sv
// Sequencer and bucket state: update, cap, pause check and wake delay per direction.
// Depends on dtbl_pkg and dtbl_div.
module dtbl_ctrl #(
   parameter int BURST_TICKS = dtbl_pkg::DEF_BURST_TICKS,
   parameter int LEVEL_BITS  = dtbl_pkg::DEF_LEVEL_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  dtbl_pkg::req_payload_type      req_payload,
   input  logic                           csr_busy,
   input  logic [dtbl_pkg::RATE_BITS-1:0] rate [2],
   input  logic [LEVEL_BITS-1:0]          cap [2],
   input  logic [1:0]                     clip,
   input  logic                           out_free,
   output logic                           load,
   output dtbl_pkg::rsp_payload_type      result
);
   import dtbl_pkg::*;

   localparam int NUM_BITS = LEVEL_BITS + 1;
   localparam logic signed [LEVEL_BITS-1:0] LvlReset =
      LEVEL_BITS'(reset_cap(BURST_TICKS));
   localparam logic signed [LEVEL_BITS-1:0] LvlMin = {1'b1, {(LEVEL_BITS-1){1'b0}}};
   localparam logic signed [LEVEL_BITS:0]   LvlMinX = {LvlMin[LEVEL_BITS-1], LvlMin};
   localparam logic signed [LEVEL_BITS-1:0] SegLvl = LEVEL_BITS'(SEGMENT);
   localparam logic [NUM_BITS-1:0]          SegM1 = NUM_BITS'(SEGMENT - 1);

   typedef enum logic [4:0] {
      C_IDLE = 5'b00001,
      C_UPD  = 5'b00010,
      C_CHK  = 5'b00100,
      C_DIV  = 5'b01000,
      C_DONE = 5'b10000
   } ctrl_state_type;

   ctrl_state_type               state_ff, state_in;
   logic                         sel_ff, sel_in;
   logic [1:0]                   cmd_ff, cmd_in;
   logic                         dir_ff, dir_in;
   logic [COUNT_BITS-1:0]        count_ff, count_in;
   logic signed [LEVEL_BITS-1:0] level_ff [2];
   logic signed [LEVEL_BITS-1:0] level_in [2];
   logic [1:0]                   stopped_ff, stopped_in;
   logic [1:0]                   changed_ff, changed_in;
   logic [WAKE_BITS-1:0]         wake_ff [2];
   logic [WAKE_BITS-1:0]         wake_in [2];
   logic [ALLOW_BITS-1:0]        allowed_ff, allowed_in;

   logic signed [LEVEL_BITS-1:0] lvl_sel;
   logic signed [LEVEL_BITS:0]   upd_opnd, upd_sum, cap_x;
   logic signed [LEVEL_BITS-1:0] upd_val;
   logic                         want;
   logic                         div_start;
   logic [NUM_BITS-1:0]          div_num;
   div_rsp_type                  div_rsp;

   assign lvl_sel = level_ff[sel_ff];
   assign cap_x   = $signed({1'b0, cap[sel_ff]});

   // One bucket update: add rate, take bytes or keep level; clamp to both ends.
   always_comb begin
      case (cmd_ff)
         CMD_TICK: upd_opnd = $signed({1'b0, LEVEL_BITS'(rate[sel_ff])});
         CMD_EAT:  upd_opnd = (dir_ff == sel_ff) ?
                              -$signed({1'b0, LEVEL_BITS'(count_ff)}) : '0;
         default:  upd_opnd = '0;
      endcase
      upd_sum = $signed({lvl_sel[LEVEL_BITS-1], lvl_sel}) + upd_opnd;
      if (upd_sum < LvlMinX) begin
         upd_val = LvlMin;
      end else if (upd_sum > cap_x) begin
         upd_val = cap_x[LEVEL_BITS-1:0];
      end else begin
         upd_val = upd_sum[LEVEL_BITS-1:0];
      end
   end

   assign want      = lvl_sel < SegLvl;
   assign div_start = (state_ff == C_CHK) && want;
   // ceil((1460 - level) / rate) as floor((1459 + rate - level) / rate)
   assign div_num   = SegM1 + NUM_BITS'(rate[sel_ff]) - {lvl_sel[LEVEL_BITS-1], lvl_sel};

   dtbl_div #(
      .NUM_BITS (NUM_BITS)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (rate[sel_ff]),
      .rsp   (div_rsp)
   );

   always_comb begin
      state_in   = state_ff;
      sel_in     = sel_ff;
      cmd_in     = cmd_ff;
      dir_in     = dir_ff;
      count_in   = count_ff;
      stopped_in = stopped_ff;
      changed_in = changed_ff;
      allowed_in = allowed_ff;
      load       = 1'b0;
      for (int i = 0; i < 2; i++) begin
         level_in[i] = level_ff[i];
         wake_in[i]  = wake_ff[i];
         // cut the bucket down after a rate write
         if (clip[i] && (level_ff[i] > $signed(cap[i]))) begin
            level_in[i] = cap[i];
         end
      end
      case (state_ff)
         C_IDLE: begin
            if (req_valid && !req_stall) begin
               cmd_in     = req_payload.cmd;
               dir_in     = req_payload.direction;
               count_in   = req_payload.byte_count;
               allowed_in = '0;
               sel_in     = DIR_READ;
               state_in   = C_UPD;
            end
         end
         C_UPD: begin
            level_in[sel_ff] = upd_val;
            sel_in = !sel_ff;
            if (sel_ff == DIR_WRITE) begin
               state_in = C_CHK;
            end
         end
         C_CHK: begin
            stopped_in[sel_ff] = want;
            changed_in[sel_ff] = want != stopped_ff[sel_ff];
            if ((cmd_ff == CMD_GET) && (dir_ff == sel_ff) && !want) begin
               allowed_in = (|lvl_sel[LEVEL_BITS-2:ALLOW_BITS]) ? '1 :
                            lvl_sel[ALLOW_BITS-1:0];
            end
            if (want) begin
               state_in = C_DIV;
            end else begin
               wake_in[sel_ff] = '0;
               sel_in   = !sel_ff;
               state_in = (sel_ff == DIR_WRITE) ? C_DONE : C_CHK;
            end
         end
         C_DIV: begin
            if (div_rsp.done) begin
               wake_in[sel_ff] = (div_rsp.quot < WAKE_BITS'(MIN_WAKE)) ?
                                 WAKE_BITS'(MIN_WAKE) : div_rsp.quot;
               sel_in   = !sel_ff;
               state_in = (sel_ff == DIR_WRITE) ? C_DONE : C_CHK;
            end
         end
         C_DONE: begin
            if (out_free) begin
               load     = 1'b1;
               state_in = C_IDLE;
            end
         end
         default: begin
            state_in = C_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != C_IDLE) || csr_busy || (|clip);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= C_IDLE;
         sel_ff      <= DIR_READ;
         level_ff[0] <= LvlReset;
         level_ff[1] <= LvlReset;
         stopped_ff  <= '0;
      end else begin
         state_ff    <= state_in;
         sel_ff      <= sel_in;
         level_ff[0] <= level_in[0];
         level_ff[1] <= level_in[1];
         stopped_ff  <= stopped_in;
      end
      cmd_ff     <= cmd_in;
      dir_ff     <= dir_in;
      count_ff   <= count_in;
      changed_ff <= changed_in;
      wake_ff[0] <= wake_in[0];
      wake_ff[1] <= wake_in[1];
      allowed_ff <= allowed_in;
   end

   assign result.allowed_bytes    = allowed_ff;
   assign result.read_paused      = stopped_ff[DIR_READ];
   assign result.write_paused     = stopped_ff[DIR_WRITE];
   assign result.read_changed     = changed_ff[DIR_READ];
   assign result.write_changed    = changed_ff[DIR_WRITE];
   assign result.read_wake_ticks  = wake_ff[DIR_READ];
   assign result.write_wake_ticks = wake_ff[DIR_WRITE];

endmodule

### rtl/core/dtbl_checker.sv
// Port-level checks of the dual token bucket limiter, bound to the top level.
// Depends on dtbl_pkg and dual_token_bucket_limiter_top.
module dtbl_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_stall,
   input dtbl_pkg::req_payload_type req_payload,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input dtbl_pkg::rsp_payload_type rsp_payload
);
   import dtbl_pkg::*;

   // one transaction at a time: busy right after acceptance
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while previous transaction in flight");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result dropped or changed");

   a_wake_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (rsp_payload.read_paused ?
             (rsp_payload.read_wake_ticks >= WAKE_BITS'(MIN_WAKE)) :
             (rsp_payload.read_wake_ticks == '0)) &&
         (rsp_payload.write_paused ?
             (rsp_payload.write_wake_ticks >= WAKE_BITS'(MIN_WAKE)) :
             (rsp_payload.write_wake_ticks == '0)))
      else $error("wake delay disagrees with pause state");

   a_allow_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.allowed_bytes != '0) |->
         rsp_payload.allowed_bytes >= ALLOW_BITS'(SEGMENT))
      else $error("allowance below one segment reported");

endmodule

bind dual_token_bucket_limiter_top dtbl_checker u_dtbl_checker (.*);
